>>> hdl/balloc_pkg.sv
// Package for the bump allocator with exact-size reuse.
// Holds the sequencer state type and the status, command and register codes.
// No dependencies.
package balloc_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	// Request commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes
	localparam logic [2:0] STAT_REUSED = 3'd0;
	localparam logic [2:0] STAT_BUMPED = 3'd1;
	localparam logic [2:0] STAT_FAIL   = 3'd2;
	localparam logic [2:0] STAT_FREED  = 3'd3;
	localparam logic [2:0] STAT_BADPTR = 3'd4;
	localparam logic [2:0] STAT_FULL   = 3'd5;

	// Configuration register indexes and widths
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARENA_UNITS = 1'd1;
	localparam logic [CFG_DATA_W-1:0] ARENA_RESET    = 13'd4096;

	// Footprint arithmetic width: wide enough for 1 + ceil(2^32 / unit size)
	localparam int NEED_W = 33;

endpackage

>>> hdl/bump_allocator_exact_reuse.sv
// Bump allocator over fixed-size units with an exact-size free table.
// Uses balloc_pkg and one balloc_ram instance for the header store.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  request   | start / busy           | cmd, size_bytes, payload_unit
//  result    | done (one-cycle pulse) | status, result_unit
//  config    | cfg_we                 | cfg_addr, cfg_wdata
//
// For each request, the accept cycle reads the header store and works out
// the footprint; the execute cycle searches the free table in parallel and
// writes back. done pulses in the cycle after execute, while the next
// request may already be accepted. After reset a clearing pass sweeps every
// header store entry with busy held high; config writes are taken throughout.
// The receiver cannot stall results.
// UNIT_BYTES must be a power of two.
module bump_allocator_exact_reuse
	import balloc_pkg::*;
#(
	parameter int ARENA_UNITS = 4096,
	parameter int FREE_SLOTS  = 32,
	parameter int UNIT_BYTES  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  cmd,
	input  logic [31:0]           size_bytes,
	input  logic [11:0]           payload_unit,
	output logic                  done,
	output logic [2:0]            status,
	output logic [11:0]           result_unit,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW       = $clog2(ARENA_UNITS);
	localparam int CW       = $clog2(ARENA_UNITS + 1);
	localparam int FI_W     = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int FC_W     = $clog2(FREE_SLOTS + 1);
	localparam int SHIFT    = $clog2(UNIT_BYTES);
	localparam int HDR_W    = CW + 1;

	// Configuration registers
	logic                  enable_q;
	logic [CFG_DATA_W-1:0] arena_q;

	// Control state
	state_t        state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cursor_q;
	logic [FC_W-1:0] count_q;

	// Request registers
	logic              cmd_q;
	logic              zero_q;
	logic              range_bad_q;
	logic [NEED_W-1:0] need_q;
	logic [AW-1:0]     blk_q;

	// Free table
	logic [AW-1:0] ft_start_q [FREE_SLOTS];
	logic [CW-1:0] ft_total_q [FREE_SLOTS];

	// Result registers
	logic        done_q;
	logic [2:0]  status_q;
	logic [11:0] result_q;

	// Header store port signals
	logic            hdr_we;
	logic [AW-1:0]   hdr_waddr;
	logic [HDR_W-1:0] hdr_wdata;
	logic [AW-1:0]   hdr_raddr;
	logic [HDR_W-1:0] hdr_rdata;

	// Execute-cycle decisions
	logic              accept;
	logic              hit;
	logic [FI_W-1:0]   hit_idx;
	logic [NEED_W-1:0] end_w;
	logic [NEED_W-1:0] cur_w;
	logic              no_room;
	logic              do_reuse;
	logic              do_bump;
	logic              do_push;
	logic [2:0]        stat_d;
	logic [AW-1:0]     unit_d;
	logic [11:0]       blk_in;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign blk_in = payload_unit - 12'd1;

	// Header store: valid bit over footprint
	assign hdr_raddr = AW'(blk_in);
	balloc_ram #(
		.WIDTH(HDR_W),
		.DEPTH(ARENA_UNITS)
	) u_hdr (
		.clk  (clk),
		.we   (hdr_we),
		.waddr(hdr_waddr),
		.wdata(hdr_wdata),
		.raddr(hdr_raddr),
		.rdata(hdr_rdata)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(ARENA_UNITS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Search the free table, most recent entry wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < FREE_SLOTS; i++) begin
			if ((FC_W'(i) < count_q) && (NEED_W'(ft_total_q[i]) == need_q)) begin
				hit     = 1'b1;
				hit_idx = FI_W'(i);
			end
		end
	end

	// Decide the outcome of the request in execute
	always_comb begin
		end_w = (NEED_W'(arena_q) > NEED_W'(ARENA_UNITS)) ? NEED_W'(ARENA_UNITS)
			: NEED_W'(arena_q);
		cur_w   = NEED_W'(cursor_q);
		no_room = (cur_w >= end_w) || ((end_w - cur_w) < need_q);
		do_reuse = 1'b0;
		do_bump  = 1'b0;
		do_push  = 1'b0;
		stat_d   = STAT_FAIL;
		unit_d   = '0;
		if (cmd_q == CMD_ALLOC) begin
			priority if (!enable_q || zero_q) begin
				stat_d = STAT_FAIL;
			end else if (hit) begin
				do_reuse = 1'b1;
				stat_d   = STAT_REUSED;
				unit_d   = ft_start_q[hit_idx];
			end else if (no_room) begin
				stat_d = STAT_FAIL;
			end else begin
				do_bump = 1'b1;
				stat_d  = STAT_BUMPED;
				unit_d  = AW'(cursor_q);
			end
		end else begin
			priority if (range_bad_q || !hdr_rdata[HDR_W-1]) begin
				stat_d = STAT_BADPTR;
			end else if (count_q >= FC_W'(FREE_SLOTS)) begin
				stat_d = STAT_FULL;
			end else begin
				do_push = 1'b1;
				stat_d  = STAT_FREED;
			end
		end
	end

	// Header store write: clearing sweep or bumped block header
	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = clr_q;
		hdr_wdata = '0;
		if (state_q == S_CLEAR) begin
			hdr_we = 1'b1;
		end else if (state_q == S_EXEC && do_bump) begin
			hdr_we    = 1'b1;
			hdr_waddr = AW'(cursor_q);
			hdr_wdata = {1'b1, CW'(need_q)};
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			arena_q  <= ARENA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE:      enable_q <= cfg_wdata[0];
				REG_ARENA_UNITS: arena_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clear counter, cursor, free count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			cursor_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_EXEC) begin
				if (do_bump) begin
					cursor_q <= CW'(cur_w + need_q);
				end
				if (do_reuse) begin
					count_q <= count_q - FC_W'(1);
				end else if (do_push) begin
					count_q <= count_q + FC_W'(1);
				end
			end
		end
	end

	// Capture the request and precompute its footprint
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd;
			zero_q      <= (size_bytes == 32'd0);
			need_q      <= NEED_W'(1) + ((NEED_W'(size_bytes) + NEED_W'(UNIT_BYTES - 1))
				>> SHIFT);
			range_bad_q <= (payload_unit == 12'd0)
				|| (32'(payload_unit) > 32'(ARENA_UNITS));
			blk_q       <= AW'(blk_in);
		end
	end

	// Free table: close the gap on reuse, append on free
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			if (do_reuse) begin
				for (int k = 0; k < FREE_SLOTS - 1; k++) begin
					if (FI_W'(k) >= hit_idx) begin
						ft_start_q[k] <= ft_start_q[k + 1];
						ft_total_q[k] <= ft_total_q[k + 1];
					end
				end
			end else if (do_push) begin
				ft_start_q[count_q[FI_W-1:0]] <= blk_q;
				ft_total_q[count_q[FI_W-1:0]] <= hdr_rdata[CW-1:0];
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= stat_d;
			result_q <= (do_reuse || do_bump) ? 12'(unit_d) + 12'd1 : 12'd0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign result_unit = result_q;

endmodule

>>> hdl/balloc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
module balloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bump_allocator_exact_reuse: directed and random requests.
// An allocator scoreboard predicts each result. Depends on balloc_pkg and the allocator RTL.

import balloc_pkg::*;

localparam int ARENA_UNITS = 4096;
localparam int FREE_SLOTS  = 32;
localparam int UNIT_BYTES  = 64;

typedef struct packed {
	logic [2:0]  status;
	logic [11:0] unit;
} alloc_result_t;

class alloc_scoreboard;
	logic          enable;
	logic [12:0]   arena_units;
	logic [12:0]   cursor;
	logic [5:0]    free_count;
	logic [11:0]   slot_start [FREE_SLOTS];
	logic [12:0]   slot_units [FREE_SLOTS];
	bit            hdr_valid [ARENA_UNITS];
	logic [12:0]   hdr_units [ARENA_UNITS];
	alloc_result_t awaited_results [$];
	logic [11:0]   live_ptrs [$];
	int            failures;

	function new();
		enable = 1'b0;
		arena_units = ARENA_RESET;
		cursor = '0;
		free_count = '0;
		failures = 0;
		foreach (hdr_valid[i]) hdr_valid[i] = 1'b0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_ENABLE) begin
			enable = data[0];
		end else if (idx == REG_ARENA_UNITS) begin
			arena_units = data;
		end
	endfunction

	function alloc_result_t alloc_outcome(logic [31:0] size_bytes);
		logic [NEED_W-1:0] need;
		logic [12:0]       limit;
		logic [12:0]       room;
		logic [11:0]       blk;
		alloc_result_t     res;
		int                idx;
		res.status = STAT_FAIL;
		res.unit = '0;
		if (!enable || size_bytes == 0) return res;
		need = 1 + (NEED_W'(size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;

		// Take the most recently freed block of exactly this footprint, keep the rest in order
		for (idx = int'(free_count) - 1; idx >= 0; idx--) begin
			if (NEED_W'(slot_units[idx]) == need) begin
				res.status = STAT_REUSED;
				res.unit = slot_start[idx] + 12'd1;
				for (int k = idx; k + 1 < int'(free_count); k++) begin
					slot_start[k] = slot_start[k + 1];
					slot_units[k] = slot_units[k + 1];
				end
				free_count--;
				return res;
			end
		end

		// Bump the cursor; a cursor past a shrunken arena leaves no room
		limit = (arena_units > ARENA_UNITS) ? 13'(ARENA_UNITS) : arena_units;
		room = (cursor < limit) ? limit - cursor : '0;
		if (NEED_W'(room) < need) return res;
		blk = cursor[11:0];
		hdr_valid[blk] = 1'b1;
		hdr_units[blk] = need[12:0];
		cursor = cursor + need[12:0];
		live_ptrs.push_back(blk + 12'd1);
		res.status = STAT_BUMPED;
		res.unit = blk + 12'd1;
		return res;
	endfunction

	function alloc_result_t free_outcome(logic [11:0] payload);
		alloc_result_t res;
		logic [11:0]   blk;
		res.status = STAT_BADPTR;
		res.unit = '0;
		// Payload zero has no header unit; any other header unit lies inside the store
		if (payload == 0) return res;
		blk = payload - 12'd1;
		if (!hdr_valid[blk]) return res;
		if (free_count >= FREE_SLOTS) begin
			res.status = STAT_FULL;
			return res;
		end
		slot_start[free_count] = blk;
		slot_units[free_count] = hdr_units[blk];
		free_count++;
		res.status = STAT_FREED;
		return res;
	endfunction

	function void note_request(logic c, logic [31:0] size_bytes, logic [11:0] payload);
		if (c == CMD_ALLOC) begin
			awaited_results.push_back(alloc_outcome(size_bytes));
		end else begin
			awaited_results.push_back(free_outcome(payload));
		end
	endfunction

	function void check_result(logic [2:0] status, logic [11:0] unit);
		alloc_result_t want;
		if (awaited_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: status %0d unit %0d", status, unit);
			return;
		end
		want = awaited_results.pop_front();
		if (status !== want.status || unit !== want.unit) begin
			failures++;
			if (failures <= 10)
				$display("mismatch: expected status %0d unit %0d, got status %0d unit %0d",
					want.status, want.unit, status, unit);
		end
	endfunction
endclass

module testbench;
	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int STALL_LIMIT    = 20000;
	localparam int PHASES         = 8;
	localparam int PHASE_REQUESTS = 120;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  busy;
	logic                  cmd          = CMD_ALLOC;
	logic [31:0]           size_bytes   = '0;
	logic [11:0]           payload_unit = '0;
	logic                  done;
	logic [2:0]            status;
	logic [11:0]           result_unit;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr     = REG_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

	alloc_scoreboard sb;
	bit              gaps_on;

	bump_allocator_exact_reuse dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.cmd,
		.size_bytes,
		.payload_unit,
		.done,
		.status,
		.result_unit,
		.cfg_we,
		.cfg_addr,
		.cfg_wdata
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Check each result in the cycle its strobe is high
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(status, result_unit);
	end

	// Abort when no request or result moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) quiet = 0;
			else quiet++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Present one request, after a random gap when gaps are on, and hold it while busy is high
	task automatic send_request(input logic c, input logic [31:0] sz, input logic [11:0] pu);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		size_bytes <= sz;
		payload_unit <= pu;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(c, sz, pu);
	endtask

	task automatic send_alloc(input logic [31:0] sz);
		send_request(CMD_ALLOC, sz, 12'($urandom()));
	endtask

	task automatic send_free(input logic [11:0] pu);
		send_request(CMD_FREE, $urandom(), pu);
	endtask

	// Drop start and hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; enable carries random upper bits
	task automatic configure(input logic en, input logic [12:0] units);
		logic [CFG_DATA_W-1:0] en_word;
		en_word = {12'($urandom()), en};
		cfg_we <= 1'b1;
		cfg_addr <= REG_ENABLE;
		cfg_wdata <= en_word;
		@(posedge clk);
		sb.write_reg(REG_ENABLE, en_word);
		cfg_addr <= REG_ARENA_UNITS;
		cfg_wdata <= units;
		@(posedge clk);
		sb.write_reg(REG_ARENA_UNITS, units);
		cfg_we <= 1'b0;
	endtask

	// Mostly frees of live blocks and allocs of small footprints, some noise
	task automatic random_request(input int free_pct);
		logic [31:0] sz;
		int          footprint;
		if ($urandom_range(0, 99) < free_pct) begin
			if (sb.live_ptrs.size() == 0 || $urandom_range(0, 9) == 0)
				send_free(12'($urandom()));
			else
				send_free(sb.live_ptrs[$urandom_range(0, sb.live_ptrs.size() - 1)]);
		end else begin
			case ($urandom_range(0, 11))
				0: sz = $urandom();
				1: sz = 32'd0;
				default: begin
					footprint = $urandom_range(2, 6);
					sz = (footprint - 2) * UNIT_BYTES + $urandom_range(1, UNIT_BYTES);
				end
			endcase
			send_alloc(sz);
		end
	endtask

	initial begin
		sb = new();
		gaps_on = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings leave the arena disabled; frees of unmarked units are rejected
		send_alloc(32'd64);
		send_free(12'd0);
		send_free(12'hFFF);
		drain();

		// Zero size, footprint rounding, huge size, reuse order, double free
		configure(1'b1, 13'd4096);
		send_alloc(32'd0);
		send_alloc(32'd1);
		send_alloc(32'd64);
		send_alloc(32'd65);
		send_alloc(32'hFFFF_FFFF);
		send_free(12'd1);
		send_free(12'd3);
		send_alloc(32'd10);
		send_alloc(32'd10);
		send_free(12'd1);
		send_free(12'd1);
		send_alloc(32'd2);
		send_alloc(32'd3);
		send_free(12'd2);
		drain();

		// Disabled arena still takes frees
		configure(1'b0, 13'd4096);
		send_free(12'd5);
		send_alloc(32'd128);
		drain();

		// Cursor beyond a shrunken arena: only exact reuse succeeds
		configure(1'b1, 13'd4);
		send_alloc(32'd1);
		send_alloc(32'd130);
		send_alloc(32'd100);

		// Random phases, each under its own settings; odd phases lean on frees
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: configure(1'b1, 13'd4096);
				1: configure(1'b1, sb.cursor + 13'($urandom_range(8, 40)));
				2: configure(1'b1, 13'h1FFF);
				3: configure(1'b1, 13'd4);
				4: configure(1'b0, 13'd4096);
				5: configure(1'b1, sb.cursor + 13'($urandom_range(0, 16)));
				6: configure(1'b1, 13'd4096);
				default: configure(1'b1, sb.cursor + 13'($urandom_range(0, 60)));
			endcase
			gaps_on = (p % 3) != 2;
			repeat (PHASE_REQUESTS) random_request((p % 2 != 0) ? 70 : 35);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
